@@ rtl/nctss_pkg.sv @@
`timescale 1ns / 1ps
// Package for the nested comment / text scanner: scan modes, pending codes,
// token codes, character constants, the transaction and control structs and is_cont.
// No dependencies.
package nctss_pkg;

	localparam int DEPTH_WIDTH_DEF  = 16;
	localparam int OFFSET_WIDTH_DEF = 16;
	localparam int CP_WIDTH         = 21;
	localparam int RES_WIDTH        = 16;

	typedef enum logic [2:0] {
		M_IDLE  = 3'd0,
		M_BODY  = 3'd1,
		M_SEG   = 3'd2,
		M_WS    = 3'd3,
		M_SLASH = 3'd4,
		M_CMT   = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		P_NONE   = 3'd0,
		P_ESC    = 3'd1,
		P_DOLLAR = 3'd2,
		P_SLASH  = 3'd3,
		P_STAR   = 3'd4
	} pend_t;

	typedef enum logic [2:0] {
		K_REJECT  = 3'd0,
		K_COMMENT = 3'd1,
		K_NEWLINE = 3'd2,
		K_BODY    = 3'd3,
		K_SEG     = 3'd4
	} kind_t;

	// Characters the scanner reacts to
	localparam logic [CP_WIDTH-1:0] CH_LF     = 21'h0A;
	localparam logic [CP_WIDTH-1:0] CH_TAB    = 21'h09;
	localparam logic [CP_WIDTH-1:0] CH_CR     = 21'h0D;
	localparam logic [CP_WIDTH-1:0] CH_SPACE  = 21'h20;
	localparam logic [CP_WIDTH-1:0] CH_DOLLAR = 21'h24;
	localparam logic [CP_WIDTH-1:0] CH_STAR   = 21'h2A;
	localparam logic [CP_WIDTH-1:0] CH_SLASH  = 21'h2F;
	localparam logic [CP_WIDTH-1:0] CH_BSLASH = 21'h5C;
	localparam logic [CP_WIDTH-1:0] CH_LBRACE = 21'h7B;
	localparam logic [CP_WIDTH-1:0] CH_RBRACE = 21'h7D;

	// One input transaction
	typedef struct packed {
		logic                scan_start;
		logic                valid_comment;
		logic                valid_newline;
		logic                valid_text_body;
		logic                valid_text_segment;
		logic                at_eof;
		logic [CP_WIDTH-1:0] code_point;
	} item_t;

	// Narrow control part of the scan state
	typedef struct packed {
		mode_t mode;
		pend_t pend;
		logic  consumed;
		logic  crossed;
		logic  lat_comment;
		logic  lat_newline;
	} ctl_t;

	// Done flag and token code of one result
	typedef struct packed {
		logic  done;
		kind_t kind;
	} res_t;

	// Operator characters that continue a statement on the next line
	function automatic logic is_cont(input logic [CP_WIDTH-1:0] c);
		return c inside {21'h2E, 21'h7C, 21'h3F, 21'h2B, 21'h2D, 21'h2A, 21'h25,
			21'h3C, 21'h3E, 21'h3D, 21'h21, 21'h26, 21'h5E, 21'h7E};
	endfunction

endpackage

@@ rtl/nctss_step.sv @@
`timescale 1ns / 1ps
// Next-state and result logic of the scanner for one character.
// Depends on nctss_pkg.
module nctss_step #(
	parameter int DEPTH_WIDTH  = nctss_pkg::DEPTH_WIDTH_DEF,
	parameter int OFFSET_WIDTH = nctss_pkg::OFFSET_WIDTH_DEF
) (
	input  nctss_pkg::item_t                 item,
	input  nctss_pkg::ctl_t                  cur_ctl,
	input  logic [DEPTH_WIDTH-1:0]           cur_depth,
	input  logic [OFFSET_WIDTH-1:0]          cur_adv,
	input  logic [OFFSET_WIDTH-1:0]          cur_skip,
	input  logic [OFFSET_WIDTH-1:0]          cur_marked,
	output nctss_pkg::ctl_t                  nxt_ctl,
	output logic [DEPTH_WIDTH-1:0]           nxt_depth,
	output logic [OFFSET_WIDTH-1:0]          nxt_adv,
	output logic [OFFSET_WIDTH-1:0]          nxt_skip,
	output logic [OFFSET_WIDTH-1:0]          nxt_marked,
	output nctss_pkg::res_t                  res,
	output logic [nctss_pkg::RES_WIDTH-1:0]  res_start,
	output logic [nctss_pkg::RES_WIDTH-1:0]  res_end
);
	import nctss_pkg::*;

	localparam logic [DEPTH_WIDTH-1:0]  DEPTH_MAX  = '1;
	localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

	ctl_t                    ctl;
	logic [DEPTH_WIDTH-1:0]  depth;
	logic [OFFSET_WIDTH-1:0] adv;
	logic [OFFSET_WIDTH-1:0] skip;
	logic [OFFSET_WIDTH-1:0] marked;
	logic [OFFSET_WIDTH-1:0] end_val;
	logic                    done;
	kind_t                   kind;
	logic                    handled;
	logic                    seg;
	logic                    eof;
	logic [CP_WIDTH-1:0]     c;
	logic [OFFSET_WIDTH+RES_WIDTH-1:0] skip_ext;
	logic [OFFSET_WIDTH+RES_WIDTH-1:0] end_ext;

	assign eof = item.at_eof;
	assign c   = item.code_point;

	always_comb begin
		ctl     = cur_ctl;
		depth   = cur_depth;
		adv     = cur_adv;
		skip    = cur_skip;
		marked  = cur_marked;
		end_val = '0;
		done    = 1'b0;
		kind    = K_REJECT;
		handled = 1'b0;

		// New scan: latch flags, clear counters, pick the mode
		if (item.scan_start) begin
			ctl.lat_comment = item.valid_comment;
			ctl.lat_newline = item.valid_newline;
			ctl.consumed    = 1'b0;
			ctl.crossed     = 1'b0;
			ctl.pend        = P_NONE;
			depth           = DEPTH_WIDTH'(1);
			adv             = '0;
			skip            = '0;
			marked          = '0;
			if (item.valid_text_body && !item.valid_newline) begin
				ctl.mode = M_BODY;
			end else if (item.valid_text_segment && !item.valid_newline) begin
				ctl.mode = M_SEG;
			end else begin
				ctl.mode = M_WS;
			end
		end

		seg = (ctl.mode == M_SEG);

		case (ctl.mode)
			// Verbatim text: brace depth, escapes, interpolation holes
			M_BODY, M_SEG: begin
				if (ctl.pend == P_ESC) begin
					ctl.pend = P_NONE;
					if (!eof && (c == CH_LBRACE || c == CH_RBRACE || c == CH_BSLASH ||
						(seg && c == CH_DOLLAR))) begin
						if (adv != OFFSET_MAX) adv = adv + OFFSET_WIDTH'(1);
						handled = 1'b1;
					end
				end else if (ctl.pend == P_DOLLAR) begin
					ctl.pend = P_NONE;
					if (!eof && c == CH_LBRACE) begin
						done    = 1'b1;
						kind    = ctl.consumed ? K_SEG : K_REJECT;
						end_val = marked;
						handled = 1'b1;
					end else begin
						ctl.consumed = 1'b1;
					end
				end
				if (!handled) begin
					if (eof) begin
						done = 1'b1;
					end else if (c == CH_BSLASH) begin
						if (adv != OFFSET_MAX) adv = adv + OFFSET_WIDTH'(1);
						ctl.pend     = P_ESC;
						ctl.consumed = 1'b1;
					end else if (seg && c == CH_DOLLAR) begin
						marked = adv;
						if (adv != OFFSET_MAX) adv = adv + OFFSET_WIDTH'(1);
						ctl.pend = P_DOLLAR;
					end else if (c == CH_RBRACE && depth <= DEPTH_WIDTH'(1)) begin
						// balancing brace ends the token before it
						done = 1'b1;
						if (ctl.consumed) begin
							marked  = adv;
							kind    = seg ? K_SEG : K_BODY;
							end_val = adv;
						end
					end else begin
						if (c == CH_RBRACE) begin
							depth = depth - DEPTH_WIDTH'(1);
						end else if (c == CH_LBRACE && depth != DEPTH_MAX) begin
							depth = depth + DEPTH_WIDTH'(1);
						end
						if (adv != OFFSET_MAX) adv = adv + OFFSET_WIDTH'(1);
						ctl.consumed = 1'b1;
					end
				end
			end
			// Leading whitespace, then comment opener or newline terminator
			M_WS: begin
				if (!eof && (c == CH_LF || c == CH_SPACE || c == CH_TAB || c == CH_CR)) begin
					if (c == CH_LF) ctl.crossed = 1'b1;
					if (adv != OFFSET_MAX) adv = adv + OFFSET_WIDTH'(1);
					if (skip != OFFSET_MAX) skip = skip + OFFSET_WIDTH'(1);
				end else if (ctl.lat_comment && !eof && c == CH_SLASH) begin
					marked = adv;
					if (adv != OFFSET_MAX) adv = adv + OFFSET_WIDTH'(1);
					ctl.mode = M_SLASH;
				end else if (ctl.lat_newline && (ctl.crossed || eof)) begin
					done = 1'b1;
					if (eof || !is_cont(c)) begin
						kind    = K_NEWLINE;
						end_val = adv;
					end
				end else begin
					done = 1'b1;
				end
			end
			// Slash seen: only a star opens the comment
			M_SLASH: begin
				if (!eof && c == CH_STAR) begin
					if (adv != OFFSET_MAX) adv = adv + OFFSET_WIDTH'(1);
					depth    = DEPTH_WIDTH'(1);
					ctl.pend = P_NONE;
					ctl.mode = M_CMT;
				end else begin
					done = 1'b1;
				end
			end
			// Inside a nestable block comment
			M_CMT: begin
				if (ctl.pend == P_SLASH) begin
					ctl.pend = P_NONE;
					if (!eof && c == CH_STAR) begin
						if (adv != OFFSET_MAX) adv = adv + OFFSET_WIDTH'(1);
						if (depth != DEPTH_MAX) depth = depth + DEPTH_WIDTH'(1);
						handled = 1'b1;
					end
				end else if (ctl.pend == P_STAR) begin
					ctl.pend = P_NONE;
					if (!eof && c == CH_SLASH) begin
						if (adv != OFFSET_MAX) adv = adv + OFFSET_WIDTH'(1);
						if (depth != '0) depth = depth - DEPTH_WIDTH'(1);
						if (depth == '0) begin
							marked  = adv;
							done    = 1'b1;
							kind    = K_COMMENT;
							end_val = adv;
						end
						handled = 1'b1;
					end
				end
				if (!handled) begin
					if (eof) begin
						done = 1'b1;
					end else begin
						if (c == CH_SLASH) begin
							ctl.pend = P_SLASH;
						end else if (c == CH_STAR) begin
							ctl.pend = P_STAR;
						end
						if (adv != OFFSET_MAX) adv = adv + OFFSET_WIDTH'(1);
					end
				end
			end
			default: begin
				ctl.mode = M_IDLE;
			end
		endcase

		if (done) ctl.mode = M_IDLE;
	end

	// Offsets leave the block as 16-bit values
	assign skip_ext = {{RES_WIDTH{1'b0}}, skip};
	assign end_ext  = {{RES_WIDTH{1'b0}}, end_val};

	assign nxt_ctl    = ctl;
	assign nxt_depth  = depth;
	assign nxt_adv    = adv;
	assign nxt_skip   = skip;
	assign nxt_marked = marked;
	assign res.done   = done;
	assign res.kind   = kind;
	assign res_start  = (done && kind != K_REJECT) ? skip_ext[RES_WIDTH-1:0] : '0;
	assign res_end    = (done && kind != K_REJECT) ? end_ext[RES_WIDTH-1:0] : '0;

endmodule

@@ rtl/nested_comment_text_scanner_unit.sv @@
`timescale 1ns / 1ps
// Top level of the nested comment / text scanner: input register, scan state
// and result register around nctss_step. Depends on nctss_pkg, nctss_step.
//
//  channel  | dir | tdata                                | tuser / tlast
//  ---------+-----+--------------------------------------+-----------------------------
//  s_axis   | in  | code_point[20:0], 3 pad bits         | scan_start, valid_comment,
//           |     |                                      | valid_newline, valid_text_body,
//           |     |                                      | valid_text_segment, at_eof
//  m_axis   | out | token_start[15:0], token_end[31:16]  | tuser token_kind, tlast scan_done
//
// One character per cycle sustained while m_axis is not stalled; every input
// transaction yields one result transaction, passed through the input register
// and then the result register. The scan state updates along with the result register.
// arst_n clears the scan state and both valid flags; the scanner is then idle.
// A stall on m_axis holds the result register; the input register takes data
// while it is empty or while the result register drains or is empty.
module nested_comment_text_scanner_unit #(
	parameter int DEPTH_WIDTH  = nctss_pkg::DEPTH_WIDTH_DEF,
	parameter int OFFSET_WIDTH = nctss_pkg::OFFSET_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // code_point[20:0], zero pad [23:21]
	input  logic [5:0]  s_axis_tuser,  // scan_start, valid_comment, valid_newline,
	                                   // valid_text_body, valid_text_segment, at_eof
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // token_start[15:0], token_end[31:16]
	output logic [2:0]  m_axis_tuser,  // token_kind
	output logic        m_axis_tlast   // scan_done
);
	import nctss_pkg::*;

	item_t                   item_s1;
	logic                    valid_s1;
	res_t                    res_s2;
	logic [RES_WIDTH-1:0]    start_s2;
	logic [RES_WIDTH-1:0]    end_s2;
	logic                    valid_s2;

	ctl_t                    ctl_q;
	logic [DEPTH_WIDTH-1:0]  depth_q;
	logic [OFFSET_WIDTH-1:0] adv_q;
	logic [OFFSET_WIDTH-1:0] skip_q;
	logic [OFFSET_WIDTH-1:0] marked_q;

	ctl_t                    nxt_ctl;
	logic [DEPTH_WIDTH-1:0]  nxt_depth;
	logic [OFFSET_WIDTH-1:0] nxt_adv;
	logic [OFFSET_WIDTH-1:0] nxt_skip;
	logic [OFFSET_WIDTH-1:0] nxt_marked;
	res_t                    res;
	logic [RES_WIDTH-1:0]    res_start;
	logic [RES_WIDTH-1:0]    res_end;

	logic                    advance;
	logic                    s_take;

	// Handshake: process when the result register is free or draining
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign s_take        = s_axis_tvalid && s_axis_tready;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_take) begin
			item_s1.scan_start         <= s_axis_tuser[0];
			item_s1.valid_comment      <= s_axis_tuser[1];
			item_s1.valid_newline      <= s_axis_tuser[2];
			item_s1.valid_text_body    <= s_axis_tuser[3];
			item_s1.valid_text_segment <= s_axis_tuser[4];
			item_s1.at_eof             <= s_axis_tuser[5];
			item_s1.code_point         <= s_axis_tdata[CP_WIDTH-1:0];
		end
	end

	nctss_step #(
		.DEPTH_WIDTH (DEPTH_WIDTH),
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_step (
		.item      (item_s1),
		.cur_ctl   (ctl_q),
		.cur_depth (depth_q),
		.cur_adv   (adv_q),
		.cur_skip  (skip_q),
		.cur_marked(marked_q),
		.nxt_ctl   (nxt_ctl),
		.nxt_depth (nxt_depth),
		.nxt_adv   (nxt_adv),
		.nxt_skip  (nxt_skip),
		.nxt_marked(nxt_marked),
		.res       (res),
		.res_start (res_start),
		.res_end   (res_end)
	);

	// Scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q    <= '{mode: M_IDLE, pend: P_NONE, default: 1'b0};
			depth_q  <= '0;
			adv_q    <= '0;
			skip_q   <= '0;
			marked_q <= '0;
		end else if (advance) begin
			ctl_q    <= nxt_ctl;
			depth_q  <= nxt_depth;
			adv_q    <= nxt_adv;
			skip_q   <= nxt_skip;
			marked_q <= nxt_marked;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2   <= res;
			start_s2 <= res_start;
			end_s2   <= res_end;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {end_s2, start_s2};
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tlast  = res_s2.done;

`ifndef SYNTH
	// A token code other than rejected only comes with the end of a scan
	a_kind_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == K_REJECT)
		else $error("token code on an unfinished scan");

	// Rejected or unfinished results carry no offsets
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == K_REJECT |-> m_axis_tdata == '0)
		else $error("offsets on a rejected result");

	// A finished scan leaves the scanner idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.done |=> ctl_q.mode == M_IDLE)
		else $error("scanner not idle after scan end");

	// No escape or delimiter is left pending once idle
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q.mode == M_IDLE |-> ctl_q.pend == P_NONE)
		else $error("pending code left while idle");
`endif

endmodule
